// ----- hw/rtl/csv_field_splitter_defines.svh -----
// Assertion helpers for the field splitter checker
`ifndef CSV_FIELD_SPLITTER_DEFINES_SVH
`define CSV_FIELD_SPLITTER_DEFINES_SVH

// Property under clk, off while rst_n is low
`define CSVS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Hold sig while a request is stalled
`define CSVS_HOLD(label, vld, rdy, sig) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> $stable(sig)) else $error("stalled request changed");

`endif

// ----- hw/rtl/csvs_pkg.sv -----
package csvs_pkg;

  localparam int SPACE_HOLD_DEPTH = 32;
  localparam int SH_AW = (SPACE_HOLD_DEPTH > 1) ? $clog2(SPACE_HOLD_DEPTH) : 1;
  localparam int SH_CW = $clog2(SPACE_HOLD_DEPTH + 1);

  localparam logic [7:0] QUOTE_CH  = 8'h22;
  localparam logic [7:0] COMMA_CH  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] FIELD_LIMIT_RST = 8'd32;

  typedef enum logic [2:0] {
    K_BYTE    = 3'd0,
    K_FEND    = 3'd1,
    K_LINE    = 3'd2,
    K_TOOMANY = 3'd3,
    K_OPENQ   = 3'd4,
    K_WSOVF   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    QM_OUT  = 2'd0,
    QM_IN   = 2'd1,
    QM_PEND = 2'd2
  } qmode_t;

  typedef enum logic [2:0] {
    WS_SPACE = 3'd0,
    WS_TAB   = 3'd1,
    WS_LF    = 3'd2,
    WS_VT    = 3'd3,
    WS_FF    = 3'd4,
    WS_CR    = 3'd5
  } ws_code_t;

  typedef struct packed {
    logic take;
    logic emit_flush;
    logic emit_prim;
    logic emit_term;
  } dp_cmd_t;

  typedef struct packed {
    logic dec_flush;
    logic dec_prim;
    logic dec_term;
    logic flush_last;
    logic term_pend;
    logic out_free;
  } dp_sts_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
           (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
  endfunction

  function automatic ws_code_t ws_code(logic [7:0] b);
    ws_code_t c;
    case (b)
      CH_TAB:  c = WS_TAB;
      CH_LF:   c = WS_LF;
      CH_VT:   c = WS_VT;
      CH_FF:   c = WS_FF;
      CH_CR:   c = WS_CR;
      default: c = WS_SPACE;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ws_char(logic [2:0] c);
    logic [7:0] b;
    case (c)
      WS_TAB:  b = CH_TAB;
      WS_LF:   b = CH_LF;
      WS_VT:   b = CH_VT;
      WS_FF:   b = CH_FF;
      WS_CR:   b = CH_CR;
      default: b = CH_SPACE;
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/csvs_in_if.sv -----
interface csvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       line_end;

  modport source (output valid, output in_byte, output line_end, input ready);
  modport sink (input valid, input in_byte, input line_end, output ready);
endinterface

// ----- hw/rtl/csvs_out_if.sv -----
interface csvs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic [7:0] field_index;
  logic       last;

  modport source (output valid, output kind, output out_byte, output field_index,
                  output last, input ready);
  modport sink (input valid, input kind, input out_byte, input field_index,
                input last, output ready);
endinterface

// ----- hw/rtl/csvs_ctrl.sv -----
module csvs_ctrl import csvs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FLUSH = 4'b0010,
    S_PRIM  = 4'b0100,
    S_TERM  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.dec_flush) begin
            state_nxt = S_FLUSH;
          end else if (sts.dec_prim) begin
            state_nxt = S_PRIM;
          end else if (sts.dec_term) begin
            state_nxt = S_TERM;
          end
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.emit_flush = 1'b1;
          if (sts.flush_last) begin
            state_nxt = S_PRIM;
          end
        end
      end
      S_PRIM: begin
        if (sts.out_free) begin
          cmd.emit_prim = 1'b1;
          state_nxt = sts.term_pend ? S_TERM : S_IDLE;
        end
      end
      S_TERM: begin
        if (sts.out_free) begin
          cmd.emit_term = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/csvs_dp.sv -----
module csvs_dp import csvs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       line_end,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte,
  output logic [7:0] out_index,
  output logic       out_last
);

  logic [7:0]       fld_lim_r;
  qmode_t           qm_r, qm_nxt;
  logic             fs_r, fs_nxt;
  logic             fhc_r, fhc_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic [SH_CW-1:0] hsc_r, hsc_nxt;
  logic             disc_r, disc_nxt;

  logic [2:0]       mem [SPACE_HOLD_DEPTH];
  logic [2:0]       rd_data_r;
  logic [SH_CW-1:0] fp_r, fp_nxt;

  logic [SH_CW-1:0] flush_n_r, flush_n_nxt;
  kind_t            prim_kind_r, prim_kind_nxt;
  logic [7:0]       prim_byte_r, prim_byte_nxt;
  logic [7:0]       prim_idx_r;
  logic             prim_last_r, prim_last_nxt;
  logic             prim_v;
  kind_t            term_kind_r, term_kind_nxt;
  logic [7:0]       term_idx_r;
  logic             term_v_r, term_v_nxt;
  logic             wr_en;

  logic             out_valid_r, out_valid_nxt;
  kind_t            kind_r;
  logic [7:0]       byte_r;
  logic [7:0]       idx_r;
  logic             last_r;

  logic [8:0]       lim9;
  logic [8:0]       cnt1;
  logic             too_many;
  logic             b_ws;
  logic             do_content, do_outside;
  logic [7:0]       cb;
  logic             err;
  kind_t            err_kind;

  assign lim9     = (fld_lim_r == 8'd0) ? 9'd1 : {1'b0, fld_lim_r};
  assign cnt1     = {1'b0, cnt_r} + 9'd1;
  assign too_many = (cnt1 >= lim9);
  assign b_ws     = is_ws(in_byte);

  always_comb begin
    qm_nxt        = qm_r;
    fs_nxt        = fs_r;
    fhc_nxt       = fhc_r;
    cnt_nxt       = cnt_r;
    hsc_nxt       = hsc_r;
    disc_nxt      = disc_r;
    do_content    = 1'b0;
    do_outside    = 1'b0;
    cb            = in_byte;
    err           = 1'b0;
    err_kind      = K_TOOMANY;
    wr_en         = 1'b0;
    flush_n_nxt   = '0;
    prim_v        = 1'b0;
    prim_kind_nxt = K_BYTE;
    prim_byte_nxt = 8'd0;
    prim_last_nxt = 1'b1;
    term_v_nxt    = 1'b0;
    term_kind_nxt = K_LINE;

    if (disc_r) begin
      if (line_end) begin
        qm_nxt   = QM_OUT;
        fs_nxt   = 1'b1;
        fhc_nxt  = 1'b0;
        cnt_nxt  = 8'd0;
        hsc_nxt  = '0;
        disc_nxt = 1'b0;
      end
    end else begin
      case (qm_r)
        QM_IN: begin
          if (in_byte == QUOTE_CH) begin
            qm_nxt = QM_PEND;
          end else begin
            do_content = 1'b1;
          end
        end
        QM_PEND: begin
          if (in_byte == QUOTE_CH) begin
            qm_nxt     = QM_IN;
            do_content = 1'b1;
          end else begin
            qm_nxt     = QM_OUT;
            do_outside = 1'b1;
          end
        end
        default: begin
          qm_nxt     = QM_OUT;
          do_outside = 1'b1;
        end
      endcase

      if (do_outside) begin
        if (in_byte == COMMA_CH) begin
          if (too_many) begin
            err      = 1'b1;
            err_kind = K_TOOMANY;
          end else begin
            prim_v        = 1'b1;
            prim_kind_nxt = K_FEND;
            cnt_nxt       = cnt1[7:0];
            fs_nxt        = 1'b1;
            fhc_nxt       = 1'b0;
            hsc_nxt       = '0;
          end
        end else if (in_byte == QUOTE_CH && fs_r) begin
          qm_nxt = QM_IN;
          fs_nxt = 1'b0;
        end else begin
          if (!b_ws) begin
            fs_nxt = 1'b0;
          end
          do_content = 1'b1;
        end
      end

      if (do_content) begin
        if (b_ws) begin
          if (fhc_r) begin
            if (hsc_r >= SH_CW'(SPACE_HOLD_DEPTH)) begin
              err      = 1'b1;
              err_kind = K_WSOVF;
            end else begin
              wr_en   = 1'b1;
              hsc_nxt = hsc_r + SH_CW'(1);
            end
          end
        end else begin
          flush_n_nxt   = hsc_r;
          hsc_nxt       = '0;
          prim_v        = 1'b1;
          prim_kind_nxt = K_BYTE;
          prim_byte_nxt = cb;
          fhc_nxt       = 1'b1;
        end
      end

      if (err) begin
        prim_v        = 1'b1;
        prim_kind_nxt = err_kind;
        prim_byte_nxt = 8'd0;
        flush_n_nxt   = '0;
      end else if (line_end) begin
        term_v_nxt    = 1'b1;
        term_kind_nxt = (qm_nxt == QM_IN) ? K_OPENQ : K_LINE;
        prim_last_nxt = 1'b0;
      end

      if (err || line_end) begin
        qm_nxt   = QM_OUT;
        fs_nxt   = 1'b1;
        fhc_nxt  = 1'b0;
        cnt_nxt  = 8'd0;
        hsc_nxt  = '0;
        disc_nxt = err && !line_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fld_lim_r    <= FIELD_LIMIT_RST;
      qm_r         <= QM_OUT;
      fs_r         <= 1'b1;
      fhc_r        <= 1'b0;
      cnt_r        <= 8'd0;
      hsc_r        <= '0;
      disc_r       <= 1'b0;
      term_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        fld_lim_r <= cfg_data;
      end
      if (cmd.take) begin
        qm_r     <= qm_nxt;
        fs_r     <= fs_nxt;
        fhc_r    <= fhc_nxt;
        cnt_r    <= cnt_nxt;
        hsc_r    <= hsc_nxt;
        disc_r   <= disc_nxt;
        term_v_r <= term_v_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      flush_n_r   <= flush_n_nxt;
      prim_kind_r <= prim_kind_nxt;
      prim_byte_r <= prim_byte_nxt;
      prim_idx_r  <= cnt_r;
      prim_last_r <= prim_last_nxt;
      term_kind_r <= term_kind_nxt;
      term_idx_r  <= (err) ? cnt_r : ((prim_kind_nxt == K_FEND && prim_v) ? cnt1[7:0] : cnt_r);
    end
  end

  // held whitespace store
  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) begin
      mem[hsc_r[SH_AW-1:0]] <= ws_code(in_byte);
    end
  end

  always_comb begin
    fp_nxt = fp_r;
    if (cmd.take) begin
      fp_nxt = '0;
    end else if (cmd.emit_flush) begin
      fp_nxt = fp_r + SH_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    fp_r      <= fp_nxt;
    rd_data_r <= mem[fp_nxt[SH_AW-1:0]];
  end

  assign out_valid_nxt = (cmd.emit_flush || cmd.emit_prim || cmd.emit_term) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_flush) begin
      kind_r <= K_BYTE;
      byte_r <= ws_char(rd_data_r);
      idx_r  <= prim_idx_r;
      last_r <= 1'b0;
    end else if (cmd.emit_prim) begin
      kind_r <= prim_kind_r;
      byte_r <= prim_byte_r;
      idx_r  <= prim_idx_r;
      last_r <= prim_last_r;
    end else if (cmd.emit_term) begin
      kind_r <= term_kind_r;
      byte_r <= 8'd0;
      idx_r  <= term_idx_r;
      last_r <= 1'b1;
    end
  end

  assign sts.dec_flush  = !disc_r && (flush_n_nxt != '0);
  assign sts.dec_prim   = !disc_r && prim_v;
  assign sts.dec_term   = !disc_r && term_v_nxt;
  assign sts.flush_last = ((fp_r + SH_CW'(1)) == flush_n_r);
  assign sts.term_pend  = term_v_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_byte  = byte_r;
  assign out_index = idx_r;
  assign out_last  = last_r;

endmodule

// ----- hw/rtl/csv_field_splitter.sv -----
// A request is taken in S_IDLE; S_FLUSH, S_PRIM and S_TERM then load its results into
//   the single output register, one result per cycle while the output register is free,
//   and the next request is taken only after the last result is loaded.
// Held-whitespace release drains the store one entry per cycle through its read port while the output register is free.
// Reset: synchronous, active-low rst_n clears line state and sets the field limit to 32;
//   the held-whitespace store is not cleared.
module csv_field_splitter import csvs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  csvs_in_if.sink           in_ch,
  csvs_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  csvs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csvs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_ch.in_byte),
    .line_end  (in_ch.line_end),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .out_byte  (out_ch.out_byte),
    .out_index (out_ch.field_index),
    .out_last  (out_ch.last)
  );

endmodule

// ----- hw/rtl/csvs_chk.sv -----
`include "csv_field_splitter_defines.svh"

module csvs_chk import csvs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [7:0] out_byte,
  input logic [7:0] out_index,
  input logic       out_last
);

  logic [19:0] out_pay;
  logic        mark_v;
  logic        line_mark_v;

  assign out_pay     = {out_kind, out_byte, out_index, out_last};
  assign mark_v      = out_valid && (out_kind != K_BYTE);
  assign line_mark_v = mark_v && (out_kind != K_FEND);

  `CSVS_HOLD(a_out_hold, out_valid, out_ready, out_pay)
  `CSVS_ASSERT(a_byte_zero, mark_v |-> (out_byte == 8'd0), "byte not zero on mark")
  `CSVS_ASSERT(a_mark_last, line_mark_v |-> out_last, "line mark not last")
  `CSVS_ASSERT(a_ready_last, (in_ready && out_valid) |-> out_last, "new request taken mid burst")

endmodule

bind csv_field_splitter csvs_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_byte  (out_ch.out_byte),
  .out_index (out_ch.field_index),
  .out_last  (out_ch.last)
);

// ----- verif/csv_token_checker.sv -----
module csv_token_checker import csvs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  csvs_in_if   in_ch,
  csvs_out_if  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] field;
    logic       last;
  } token_t;

  token_t     expected_tokens[$];
  token_t     burst[$];
  logic [7:0] held_blanks[$];
  logic [7:0] field_limit;
  qmode_t     quote_mode;
  logic       fresh_field;
  logic       field_nonempty;
  logic [7:0] fields_done;
  logic       skipping_line;
  int         errors = 0;

  function automatic logic is_blank(logic [7:0] b);
    case (b)
      CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function void push_token(kind_t k, logic [7:0] b);
    token_t t;
    t.kind  = k;
    t.data  = (k == K_BYTE) ? b : 8'd0;
    t.field = fields_done;
    t.last  = 1'b0;
    burst.push_back(t);
  endfunction

  function void restart_line();
    quote_mode     = QM_OUT;
    fresh_field    = 1'b1;
    field_nonempty = 1'b0;
    fields_done    = 8'd0;
    skipping_line  = 1'b0;
    held_blanks.delete();
  endfunction

  function kind_t take_content(logic [7:0] b);
    int i;
    if (is_blank(b)) begin
      if (!field_nonempty) return K_BYTE;
      if (held_blanks.size() >= SPACE_HOLD_DEPTH) return K_WSOVF;
      held_blanks.push_back(b);
      return K_BYTE;
    end
    for (i = 0; i < held_blanks.size(); i++) push_token(K_BYTE, held_blanks[i]);
    held_blanks.delete();
    push_token(K_BYTE, b);
    field_nonempty = 1'b1;
    return K_BYTE;
  endfunction

  function kind_t take_unquoted(logic [7:0] b);
    int lim;
    lim = (field_limit == 8'd0) ? 1 : int'(field_limit);
    if (b == COMMA_CH) begin
      if (int'(fields_done) + 1 >= lim) return K_TOOMANY;
      push_token(K_FEND, 8'd0);
      fields_done    = fields_done + 8'd1;
      fresh_field    = 1'b1;
      field_nonempty = 1'b0;
      held_blanks.delete();
      return K_BYTE;
    end
    if (b == QUOTE_CH && fresh_field) begin
      quote_mode  = QM_IN;
      fresh_field = 1'b0;
      return K_BYTE;
    end
    if (!is_blank(b)) fresh_field = 1'b0;
    return take_content(b);
  endfunction

  function void tokenize_byte(logic [7:0] b, logic fin);
    kind_t fault;
    token_t t;
    int i;
    burst.delete();
    fault = K_BYTE;
    if (skipping_line) begin
      if (fin) restart_line();
      return;
    end
    case (quote_mode)
      QM_IN: begin
        if (b == QUOTE_CH) quote_mode = QM_PEND;
        else fault = take_content(b);
      end
      QM_PEND: begin
        if (b == QUOTE_CH) begin
          quote_mode = QM_IN;
          fault = take_content(QUOTE_CH);
        end else begin
          quote_mode = QM_OUT;
          fault = take_unquoted(b);
        end
      end
      default: begin
        quote_mode = QM_OUT;
        fault = take_unquoted(b);
      end
    endcase
    if (fault != K_BYTE) begin
      push_token(fault, 8'd0);
      restart_line();
      skipping_line = !fin;
    end else if (fin) begin
      push_token((quote_mode == QM_IN) ? K_OPENQ : K_LINE, 8'd0);
      restart_line();
    end
    for (i = 0; i < burst.size(); i++) begin
      t = burst[i];
      t.last = (i == burst.size() - 1);
      expected_tokens.push_back(t);
    end
  endfunction

  function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    token_t want;
    if (!rst_n) begin
      field_limit = FIELD_LIMIT_RST;
      restart_line();
      expected_tokens.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected result: kind %0d, out_byte %0d, field_index %0d",
                 out_ch.kind, out_ch.out_byte, out_ch.field_index);
          errors++;
        end else begin
          want = expected_tokens.pop_front();
          compare_field("kind", 8'(want.kind), 8'(out_ch.kind));
          compare_field("out_byte", want.data, out_ch.out_byte);
          compare_field("field_index", want.field, out_ch.field_index);
          compare_field("last", 8'(want.last), 8'(out_ch.last));
        end
      end
      if (cfg_we) field_limit = cfg_data;
      if (in_ch.valid && in_ch.ready) tokenize_byte(in_ch.in_byte, in_ch.line_end);
    end
    expected_left <= expected_tokens.size();
    fail_count    <= errors;
  end

endmodule

// ----- verif/testbench.sv -----
module testbench import csvs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_data;
  int         fail_count;
  int         expected_left;
  int         idle_cycles;
  logic       quiet;
  logic [7:0] line_buf[$];

  int phase_cfg[7] = '{255, 1, 2, 3, 7, 32, 0};
  int phase_len[7] = '{15, 15, 15, 15, 15, 20, 25};

  csvs_in_if  in_ch();
  csvs_out_if out_ch();

  csv_field_splitter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  csv_token_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return blank_char();
    if (r == 9) return 8'($urandom_range(128, 255));
    c = 8'($urandom_range(33, 126));
    if (c == QUOTE_CH || c == COMMA_CH) c = 8'h78;
    return c;
  endfunction

  function void add_blanks(int n);
    repeat (n) line_buf.push_back(blank_char());
  endfunction

  function void add_plain_field();
    add_blanks($urandom_range(0, 2));
    repeat ($urandom_range(0, 5)) line_buf.push_back(plain_char());
    add_blanks($urandom_range(0, 3));
  endfunction

  function void add_quoted_field(logic closed);
    add_blanks($urandom_range(0, 2));
    line_buf.push_back(QUOTE_CH);
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 5))
        0: line_buf.push_back(COMMA_CH);
        1: begin
          line_buf.push_back(QUOTE_CH);
          line_buf.push_back(QUOTE_CH);
        end
        2: line_buf.push_back(blank_char());
        default: line_buf.push_back(plain_char());
      endcase
    end
    if (closed) begin
      line_buf.push_back(QUOTE_CH);
      if ($urandom_range(0, 3) == 0) begin
        line_buf.push_back(8'h6B);
        line_buf.push_back(QUOTE_CH);
      end
      add_blanks($urandom_range(0, 2));
    end
  endfunction

  function void add_long_run();
    line_buf.push_back(8'h6D);
    add_blanks($urandom_range(30, 34));
    if ($urandom_range(0, 1) == 0) line_buf.push_back(8'h6E);
  endfunction

  function void build_line();
    int r;
    int nf;
    int f;
    line_buf.delete();
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 3))
          0: line_buf.push_back(QUOTE_CH);
          1: line_buf.push_back(COMMA_CH);
          2: line_buf.push_back(blank_char());
          default: line_buf.push_back(8'($urandom_range(1, 255)));
        endcase
      end
    end else begin
      nf = $urandom_range(1, 5);
      for (f = 0; f < nf; f++) begin
        if (f > 0) line_buf.push_back(COMMA_CH);
        r = $urandom_range(0, 99);
        if (r < 8) add_long_run();
        else if (r < 45) add_quoted_field(!(f == nf - 1 && $urandom_range(0, 7) == 0));
        else add_plain_field();
      end
    end
    if (line_buf.size() == 0) line_buf.push_back(8'h65);
  endfunction

  task automatic send_char(input logic [7:0] b, input logic fin);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_byte  <= b;
    in_ch.line_end <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_line();
    int i;
    for (i = 0; i < line_buf.size(); i++) send_char(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic send_text(input string s);
    int i;
    line_buf.delete();
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line();
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_field_limit(input logic [7:0] v);
    cfg_data <= v;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int p;
    int sent;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = 8'd0;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = 8'd0;
    in_ch.line_end = 1'b0;
    quiet          = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    line_buf = '{8'hFF};
    send_line();
    line_buf = '{8'h01};
    send_line();
    send_text(" \"a,\"\"\" q\"");
    send_text("\"x\"");
    send_text("\"ab");

    drain();
    set_field_limit(8'd1);
    send_text("a,b");
    send_text(",");

    for (p = 0; p < 7; p++) begin
      drain();
      set_field_limit((p == 6) ? 8'($urandom_range(4, 254)) : 8'(phase_cfg[p]));
      if (phase_cfg[p] == 255) begin
        quiet = 1'b1;
        line_buf.delete();
        repeat (255) line_buf.push_back(COMMA_CH);
        send_line();
      end
      sent = 0;
      while (sent < phase_len[p]) begin
        build_line();
        quiet = ($urandom_range(0, 3) == 0);
        sent += line_buf.size();
        send_line();
      end
    end
    drain();

    if (fail_count == 0 && expected_left == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
